// ----- sv/mcp_pkg.sv -----
// Shared constants for the min/max contiguous partition unit.
// No dependencies; used by the top level.
package mcp_pkg;

    localparam int MAX_ITEMS_DEF   = 1024;
    localparam int AMOUNT_BITS_DEF = 16;

    localparam int AMOUNT_W = 16;
    localparam int GROUP_W  = 11;
    localparam int RESULT_W = 26;

    localparam logic [GROUP_W-1:0] GROUP_COUNT_RESET = GROUP_W'(1);

endpackage

// ----- sv/mcp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mcp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/min_max_contiguous_partition_unit.sv -----
// Amounts are loaded one per cycle into a single RAM (one transaction per cycle while
// loading). A transaction with last set starts a binary search over the bound between the
// largest amount and the set total: about log2(total - largest) + 1 probes, each walking
// the N stored amounts through the RAM read port at one per cycle. Input is stalled during
// the search; a finished result waits in the output register while the next set loads.
// The group count register may be written at any time the unit is idle.
// Depends on mcp_pkg and mcp_ram.
module min_max_contiguous_partition_unit #(
    parameter int MAX_ITEMS   = mcp_pkg::MAX_ITEMS_DEF,
    parameter int AMOUNT_BITS = mcp_pkg::AMOUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mcp_pkg::AMOUNT_W-1:0]  amount,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mcp_pkg::RESULT_W-1:0]  min_max_sum,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mcp_pkg::GROUP_W-1:0]   group_count
);

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int TOT_W  = AMOUNT_BITS + CNT_W;
    localparam int GRP_W  = CNT_W + 1;
    localparam int CMP_W  = (GRP_W > mcp_pkg::GROUP_W) ? GRP_W : mcp_pkg::GROUP_W;
    localparam int EXT_W  = TOT_W + mcp_pkg::RESULT_W;

    typedef enum logic [2:0] {
        S_LOAD,
        S_CHECK,
        S_PROBE,
        S_DECIDE,
        S_EMIT
    } state_t;

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [TOT_W-1:0]              total_reg, total_next;
    logic [AMOUNT_BITS-1:0]        largest_reg, largest_next;
    logic [TOT_W-1:0]              lo_reg, lo_next;
    logic [TOT_W-1:0]              hi_reg, hi_next;
    logic [TOT_W-1:0]              mid_reg, mid_next;
    logic [CNT_W-1:0]              issue_reg, issue_next;
    logic                          rd_vld_reg, rd_vld_next;
    logic [TOT_W-1:0]              acc_reg, acc_next;
    logic [GRP_W-1:0]              groups_reg, groups_next;
    logic [mcp_pkg::GROUP_W-1:0]   gcount_reg, gcount_next;
    logic                          out_valid_reg, out_valid_next;
    logic [mcp_pkg::RESULT_W-1:0]  result_reg, result_next;

    logic [AMOUNT_BITS-1:0] amt_in;
    logic                   in_accept;
    logic                   room;
    logic                   store;
    logic [TOT_W-1:0]       total_add;
    logic [AMOUNT_BITS-1:0] largest_upd;
    logic                   rd_en;
    logic [AMOUNT_BITS-1:0] rd_data;
    logic [TOT_W:0]         sum_w;
    logic                   sum_fits;
    logic [TOT_W:0]         mid_sum;
    logic                   bound_fits;
    logic                   out_free;
    logic [EXT_W-1:0]       lo_ext;

    assign amt_in      = AMOUNT_BITS'(amount);
    assign in_accept   = in_valid && (state_reg == S_LOAD);
    assign room        = count_reg < CNT_W'(MAX_ITEMS);
    assign store       = in_accept && room;
    assign total_add   = total_reg + TOT_W'(amt_in);
    assign largest_upd = (amt_in > largest_reg) ? amt_in : largest_reg;
    assign rd_en       = (state_reg == S_PROBE) && (issue_reg < count_reg);
    assign sum_w       = {1'b0, acc_reg} + (TOT_W + 1)'(rd_data);
    assign sum_fits    = sum_w <= {1'b0, mid_reg};
    assign mid_sum     = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign bound_fits  = CMP_W'(groups_reg) <= CMP_W'(gcount_reg);
    assign out_free    = !out_valid_reg || !out_stall;
    assign lo_ext      = EXT_W'(lo_reg);

    mcp_ram #(
        .WIDTH (AMOUNT_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk     (clk),
        .wr_en   (store),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (amt_in),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        largest_next   = largest_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        issue_next     = issue_reg;
        rd_vld_next    = 1'b0;
        acc_next       = acc_reg;
        groups_next    = groups_reg;
        gcount_next    = gcount_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cfg_valid)
        begin
            gcount_next = group_count;
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (store)
                begin
                    count_next   = count_reg + CNT_W'(1);
                    total_next   = total_add;
                    largest_next = largest_upd;
                end
                if (in_accept && last)
                begin
                    lo_next    = TOT_W'(store ? largest_upd : largest_reg);
                    hi_next    = store ? total_add : total_reg;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next    = mid_sum[TOT_W:1];
                    issue_next  = '0;
                    acc_next    = '0;
                    groups_next = GRP_W'(1);
                    state_next  = S_PROBE;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_PROBE:
            begin
                rd_vld_next = rd_en;
                if (rd_en)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (sum_fits)
                    begin
                        acc_next = sum_w[TOT_W-1:0];
                    end
                    else
                    begin
                        groups_next = groups_reg + GRP_W'(1);
                        acc_next    = TOT_W'(rd_data);
                    end
                end
                if (!rd_en && !rd_vld_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (bound_fits)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + TOT_W'(1);
                end
                state_next = S_CHECK;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    result_next    = lo_ext[mcp_pkg::RESULT_W-1:0];
                    out_valid_next = 1'b1;
                    count_next     = '0;
                    total_next     = '0;
                    largest_next   = '0;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            total_reg     <= '0;
            largest_reg   <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            issue_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            acc_reg       <= '0;
            groups_reg    <= GRP_W'(1);
            gcount_reg    <= mcp_pkg::GROUP_COUNT_RESET;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            largest_reg   <= largest_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            mid_reg       <= mid_next;
            issue_reg     <= issue_next;
            rd_vld_reg    <= rd_vld_next;
            acc_reg       <= acc_next;
            groups_reg    <= groups_next;
            gcount_reg    <= gcount_next;
            out_valid_reg <= out_valid_next;
            result_reg    <= result_next;
        end
    end

    assign in_stall    = (state_reg != S_LOAD);
    assign out_valid   = out_valid_reg;
    assign min_max_sum = result_reg;
    assign cfg_ready   = 1'b1;

    // search window never inverts
    a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE || state_reg == S_DECIDE) |-> (lo_reg <= mid_reg) && (mid_reg < hi_reg))
        else $error("probe bound outside search window");

    // upper bound only shrinks and lower bound only grows during the search
    a_hi_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) |=> (hi_reg <= $past(hi_reg)) && (lo_reg >= $past(lo_reg)))
        else $error("search window grew");

    // read walk stays within the loaded amounts; groups stay nonzero and at most one past the count
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (issue_reg <= count_reg) && (groups_reg != '0)
            && (CMP_W'(groups_reg) <= CMP_W'(count_reg) + CMP_W'(1)))
        else $error("probe walk out of range");

endmodule

// ----- dv/mcp_result_checker.sv -----
// Result checker for min_max_contiguous_partition_unit: watches the input, output and
// group-count channels, predicts each set's smallest largest-group sum and compares.
// Depends on mcp_pkg.
module mcp_result_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [mcp_pkg::AMOUNT_W-1:0] amount,
    input  logic                         last,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [mcp_pkg::RESULT_W-1:0] min_max_sum,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [mcp_pkg::GROUP_W-1:0]  group_count,
    output int                           errors,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [mcp_pkg::AMOUNT_W-1:0] held_amounts [mcp_pkg::MAX_ITEMS_DEF];
    int                           held_count;
    logic [mcp_pkg::RESULT_W-1:0] set_total;
    logic [mcp_pkg::AMOUNT_W-1:0] set_largest;
    logic [mcp_pkg::GROUP_W-1:0]  group_limit;
    logic [mcp_pkg::RESULT_W-1:0] sums_due [$];
    logic [mcp_pkg::RESULT_W-1:0] due_sum;

    task automatic report_mismatch(input string what,
                                   input logic [mcp_pkg::RESULT_W-1:0] got,
                                   input logic [mcp_pkg::RESULT_W-1:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // greedy walk: close a group whenever the next amount would overflow the bound
    function automatic bit split_fits(input logic [mcp_pkg::RESULT_W-1:0] bound);
        longint unsigned groups;
        longint unsigned acc;
        groups = 1;
        acc = 0;
        for (int i = 0; i < held_count; i++)
        begin
            if (acc + held_amounts[i] <= bound)
                acc += held_amounts[i];
            else
            begin
                groups++;
                acc = held_amounts[i];
            end
        end
        return groups <= group_limit;
    endfunction

    function automatic logic [mcp_pkg::RESULT_W-1:0] smallest_bound();
        logic [mcp_pkg::RESULT_W-1:0] lo;
        logic [mcp_pkg::RESULT_W-1:0] hi;
        logic [mcp_pkg::RESULT_W-1:0] mid;
        lo = mcp_pkg::RESULT_W'(set_largest);
        hi = set_total;
        while (lo < hi)
        begin
            mid = lo + ((hi - lo) >> 1);
            if (split_fits(mid))
                hi = mid;
            else
                lo = mid + 1'b1;
        end
        return lo;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count = 0;
            set_total = '0;
            set_largest = '0;
            group_limit = mcp_pkg::GROUP_COUNT_RESET;
            sums_due.delete();
            errors = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                group_limit = group_count;

            if (out_valid && !out_stall)
            begin
                if (sums_due.size() == 0)
                    report_mismatch("result with none expected", min_max_sum, '0);
                else
                begin
                    due_sum = sums_due.pop_front();
                    if (min_max_sum !== due_sum)
                        report_mismatch("min_max_sum", min_max_sum, due_sum);
                end
            end

            if (in_valid && !in_stall)
            begin
                // amounts beyond a full store are dropped, but last still counts
                if (held_count < mcp_pkg::MAX_ITEMS_DEF)
                begin
                    held_amounts[held_count] = amount;
                    held_count++;
                    set_total = set_total + mcp_pkg::RESULT_W'(amount);
                    if (amount > set_largest)
                        set_largest = amount;
                end
                if (last)
                begin
                    sums_due = {sums_due, smallest_bound()};
                    held_count = 0;
                    set_total = '0;
                    set_largest = '0;
                end
            end

            pending <= sums_due.size();
        end
    end

endmodule

// ----- dv/tb_min_max_contiguous_partition_unit.sv -----
// Testbench top for min_max_contiguous_partition_unit: clock, reset, amount and
// group-count stimulus, receiver stalls and the verdict.
// Depends on mcp_pkg, the unit and mcp_result_checker.
module tb_min_max_contiguous_partition_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int SETTLE       = 40;
    localparam int RANDOM_ITEMS = 500;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [mcp_pkg::AMOUNT_W-1:0] amount = '0;
    logic                         last = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [mcp_pkg::RESULT_W-1:0] min_max_sum;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [mcp_pkg::GROUP_W-1:0]  group_count = mcp_pkg::GROUP_COUNT_RESET;

    int   errors;
    int   pending;
    int   cycle_count = 0;
    int   burst_left = 0;
    int   random_items = 0;
    int   stall_seg = 0;
    int   stall_pct = 0;
    logic hold_start = 1'b0;
    logic long_hold = 1'b0;

    min_max_contiguous_partition_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .amount      (amount),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .min_max_sum (min_max_sum),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .group_count (group_count)
    );

    mcp_result_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .amount      (amount),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .min_max_sum (min_max_sum),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .group_count (group_count),
        .errors      (errors),
        .pending     (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: segments of varying stall density, overridden by the long hold
    always @(posedge clk)
    begin
        if (long_hold)
            out_stall <= 1'b1;
        else
        begin
            if (stall_seg == 0)
            begin
                stall_seg = $urandom_range(1, 60);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    2: stall_pct = 60;
                    default: stall_pct = 95;
                endcase
            end
            stall_seg--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial
    begin
        wait (hold_start);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    task automatic send_item(input logic [mcp_pkg::AMOUNT_W-1:0] a, input logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 10);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 60);
        end
        in_valid <= 1'b1;
        amount <= a;
        last <= is_last;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_groups(input logic [mcp_pkg::GROUP_W-1:0] value);
        cfg_valid <= 1'b1;
        group_count <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_set();
        int n;
        int mode;
        int r;
        logic [mcp_pkg::AMOUNT_W-1:0] a;
        r = $urandom_range(0, 9);
        if (r < 7)
            n = $urandom_range(1, 10);
        else if (r < 9)
            n = $urandom_range(11, 40);
        else
            n = $urandom_range(41, 120);
        mode = $urandom_range(0, 9);
        for (int i = 0; i < n; i++)
        begin
            case (mode)
                0, 1, 2, 3: a = mcp_pkg::AMOUNT_W'($urandom_range(0, 65535));
                4, 5:       a = mcp_pkg::AMOUNT_W'($urandom_range(0, 15));
                6:          a = mcp_pkg::AMOUNT_W'($urandom_range(65280, 65535));
                7, 8:       a = $urandom_range(0, 1) ? '0 : mcp_pkg::AMOUNT_W'($urandom);
                default:    a = '0;
            endcase
            send_item(a, i == n - 1);
        end
        random_items += n;
    endtask

    task automatic pick_groups();
        case ($urandom_range(0, 11))
            0:       set_groups('0);
            1:       set_groups('1);
            2:       set_groups(mcp_pkg::GROUP_W'(1024));
            3:       set_groups(mcp_pkg::GROUP_W'(1));
            4:       set_groups(mcp_pkg::GROUP_W'($urandom_range(9, 1023)));
            default: set_groups(mcp_pkg::GROUP_W'($urandom_range(2, 8)));
        endcase
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed sets at the reset group count
        send_item(16'd0, 1'b1);
        send_item(16'hFFFF, 1'b1);
        repeat (2) send_item(16'd0, 1'b0);
        send_item(16'd0, 1'b1);
        repeat (3) send_item(16'hFFFF, 1'b0);
        send_item(16'hFFFF, 1'b1);
        for (int i = 1; i <= 5; i++)
            send_item(mcp_pkg::AMOUNT_W'(i), i == 5);
        drain();

        set_groups('0);
        send_item(16'd7, 1'b0);
        send_item(16'd8, 1'b0);
        send_item(16'd9, 1'b1);
        drain();

        set_groups('1);
        send_item(16'd3, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'd1, 1'b1);
        drain();

        set_groups(mcp_pkg::GROUP_W'(2));
        for (int i = 1; i <= 5; i++)
            send_item(mcp_pkg::AMOUNT_W'(i), i == 5);
        drain();

        hold_start = 1'b1;
        while (random_items < RANDOM_ITEMS)
        begin
            pick_groups();
            repeat ($urandom_range(3, 6)) send_random_set();
            drain();
        end

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
